[hdl/pgr_pkg.sv]
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared widths, codes and types for the pointer gesture recognizer.
// ----------------------------------------------------------------------------
package pgr_pkg;

  localparam int SUM_W    = 16;
  localparam int THR_W    = 15;
  localparam int ADDR_W   = 16;
  localparam int KBD_W    = 8;
  localparam int DIR_W    = 3;
  localparam int MODE_W   = 2;
  localparam int PHASE_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;

  localparam int KEYCODE_OFFSET_DEF = 6;

  // input beat kinds
  localparam logic [MODE_W-1:0] MODE_PRESS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOTION  = 2'd2;

  // gesture phase
  localparam logic [PHASE_W-1:0] PH_INACTIVE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SCANNING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ACTIVATED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG_THR = 1'd1;

  // event kinds
  localparam logic EV_PRESSED  = 1'b0;
  localparam logic EV_RELEASED = 1'b1;

  // directions
  localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd1;
  localparam logic [DIR_W-1:0] DIR_UP         = 3'd2;
  localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd3;
  localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd4;
  localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd5;
  localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd6;
  localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd7;

  typedef struct packed {
    logic             hit;
    logic [DIR_W-1:0] dir;
  } class_t;

  typedef struct packed {
    logic              kind;
    logic [DIR_W-1:0]  dir;
    logic [ADDR_W-1:0] addr;
    logic [KBD_W-1:0]  owner;
  } result_t;

endpackage

[hdl/pointer_gesture_recognizer.sv]
// ----------------------------------------------------------------------------
// pointer_gesture_recognizer
// Directional pointer gesture detection while a gesture key is held.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tuser: mode; tdata: dx, dy, table_base, kbd id
// m_*       out  tvalid/tready      tuser: event_kind; tdata: dir, addr, owner
// cfg_*     in   cfg_we (no wait)   cfg_index selects move/diag threshold
//
// One beat per cycle is taken while s_tready is high. The press/release/motion
// decision, the saturating add and the direction pick are done in the accept
// cycle; the event is registered in the output slot, or in the skid slot.
// A second output slot (skid) lets a beat be taken while an event waits;
// s_tready drops only while both slots are full.
// rst is synchronous and returns the block to inactive with zero thresholds.
//
module pointer_gesture_recognizer #(
  parameter int KEYCODE_OFFSET = pgr_pkg::KEYCODE_OFFSET_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] motion_dx, [31:16] motion_dy, [47:32] table_base, [55:48] keyboard_id
  input  logic [pgr_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] mode
  input  logic [pgr_pkg::MODE_W-1:0]        s_tuser,
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [2:0] direction, [18:3] keycode_address, [26:19] owner_keyboard, rest zero
  output logic [pgr_pkg::M_TDATA_W-1:0]     m_tdata,
  // [0] event_kind
  output logic                              m_tuser,
  // configuration
  input  logic                              cfg_we,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgr_pkg::THR_W-1:0]         cfg_data
);

  localparam int SW = pgr_pkg::SUM_W;
  localparam int AW = pgr_pkg::ADDR_W;
  localparam int KW = pgr_pkg::KBD_W;
  localparam int DW = pgr_pkg::DIR_W;

  // configuration
  logic [pgr_pkg::THR_W-1:0] move_thr, diag_thr;

  // gesture state
  logic [pgr_pkg::PHASE_W-1:0] phase, phase_next;
  logic signed [SW-1:0]        sum_x, sum_y, sum_x_next, sum_y_next;
  logic signed [SW-1:0]        acc_x, acc_y;
  logic [AW-1:0]               latched_base, latched_base_next;
  logic [KW-1:0]               latched_keyboard, latched_keyboard_next;
  logic [DW-1:0]               fired_direction, fired_direction_next;

  // output slots
  logic              out_valid, skid_valid;
  pgr_pkg::result_t  out_res, skid_res;

  // beat fields
  logic [pgr_pkg::MODE_W-1:0] mode;
  logic signed [SW-1:0]       dx, dy;
  logic [AW-1:0]              tbase;
  logic [KW-1:0]              kbd;

  logic              s_acc, m_acc;
  logic              emit;
  logic              emit_kind;
  logic [DW-1:0]     emit_dir;
  pgr_pkg::result_t  new_res;
  pgr_pkg::class_t   cls;

  assign mode  = s_tuser;
  assign dx    = s_tdata[15:0];
  assign dy    = s_tdata[31:16];
  assign tbase = s_tdata[47:32];
  assign kbd   = s_tdata[55:48];

  assign s_tready = !skid_valid;
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = out_valid && m_tready;

  pgr_classify u_classify (
    .sum_x      (sum_x),
    .sum_y      (sum_y),
    .dx         (dx),
    .dy         (dy),
    .move_thr   (move_thr),
    .diag_thr   (diag_thr),
    .sum_x_next (acc_x),
    .sum_y_next (acc_y),
    .cls        (cls)
  );

  // per-beat decision
  always_comb begin
    phase_next            = phase;
    sum_x_next            = sum_x;
    sum_y_next            = sum_y;
    latched_base_next     = latched_base;
    latched_keyboard_next = latched_keyboard;
    fired_direction_next  = fired_direction;
    emit                  = 1'b0;
    emit_kind             = pgr_pkg::EV_PRESSED;
    emit_dir              = fired_direction;

    if (s_acc) begin
      unique case (mode)
        pgr_pkg::MODE_PRESS: begin
          if (phase == pgr_pkg::PH_INACTIVE) begin
            sum_x_next            = '0;
            sum_y_next            = '0;
            latched_base_next     = tbase;
            latched_keyboard_next = kbd;
            phase_next            = pgr_pkg::PH_SCANNING;
          end
        end
        pgr_pkg::MODE_RELEASE: begin
          // released event only if a gesture fired; scanning ends silently
          if (phase == pgr_pkg::PH_ACTIVATED) begin
            emit      = 1'b1;
            emit_kind = pgr_pkg::EV_RELEASED;
          end
          phase_next = pgr_pkg::PH_INACTIVE;
        end
        pgr_pkg::MODE_MOTION: begin
          if (phase == pgr_pkg::PH_SCANNING) begin
            sum_x_next = acc_x;
            sum_y_next = acc_y;
            if (cls.hit) begin
              fired_direction_next = cls.dir;
              phase_next           = pgr_pkg::PH_ACTIVATED;
              emit                 = 1'b1;
              emit_kind            = pgr_pkg::EV_PRESSED;
              emit_dir             = cls.dir;
            end
          end
        end
        default: begin
          // unused mode: no effect
        end
      endcase
    end

    new_res.kind  = emit_kind;
    new_res.dir   = emit_dir;
    new_res.addr  = latched_base + AW'(KEYCODE_OFFSET) + AW'({emit_dir, 1'b0});
    new_res.owner = latched_keyboard;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_thr         <= '0;
      diag_thr         <= '0;
      phase            <= pgr_pkg::PH_INACTIVE;
      sum_x            <= '0;
      sum_y            <= '0;
      latched_base     <= '0;
      latched_keyboard <= '0;
      fired_direction  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pgr_pkg::REG_MOVE_THR: move_thr <= cfg_data;
          pgr_pkg::REG_DIAG_THR: diag_thr <= cfg_data;
          default: ;
        endcase
      end
      phase            <= phase_next;
      sum_x            <= sum_x_next;
      sum_y            <= sum_y_next;
      latched_base     <= latched_base_next;
      latched_keyboard <= latched_keyboard_next;
      fired_direction  <= fired_direction_next;
    end
  end

  // output register plus skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_acc) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= emit;
        end else begin
          out_valid  <= emit;
        end
      end else if (emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_acc) begin
      if (skid_valid) begin
        out_res <= skid_res;
        if (emit) skid_res <= new_res;
      end else if (emit) begin
        out_res <= new_res;
      end
    end else if (emit) begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {{(pgr_pkg::M_TDATA_W - DW - AW - KW){1'b0}},
                     out_res.owner, out_res.addr, out_res.dir};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // the skid slot only fills behind a waiting event
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds an event while output slot is empty");

  // a pressed event always leaves the block activated
  a_press_activates: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_kind == pgr_pkg::EV_PRESSED) |=> phase == pgr_pkg::PH_ACTIVATED)
    else $error("pressed event without entering activated");

  // a release beat always ends the gesture
  a_release_ends: assert property (@(posedge clk) disable iff (rst)
    (s_acc && mode == pgr_pkg::MODE_RELEASE) |=> phase == pgr_pkg::PH_INACTIVE)
    else $error("release beat did not return to inactive");

  // released events carry the direction that fired
  a_release_dir: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_kind == pgr_pkg::EV_RELEASED) |-> emit_dir == fired_direction)
    else $error("released event direction differs from fired direction");

endmodule

[hdl/pgr_classify.sv]
// ----------------------------------------------------------------------------
// pgr_classify
// Saturating accumulate of one motion report and direction priority pick.
// ----------------------------------------------------------------------------
module pgr_classify (
  input  logic signed [pgr_pkg::SUM_W-1:0] sum_x,
  input  logic signed [pgr_pkg::SUM_W-1:0] sum_y,
  input  logic signed [pgr_pkg::SUM_W-1:0] dx,
  input  logic signed [pgr_pkg::SUM_W-1:0] dy,
  input  logic        [pgr_pkg::THR_W-1:0] move_thr,
  input  logic        [pgr_pkg::THR_W-1:0] diag_thr,
  output logic signed [pgr_pkg::SUM_W-1:0] sum_x_next,
  output logic signed [pgr_pkg::SUM_W-1:0] sum_y_next,
  output pgr_pkg::class_t                  cls
);

  localparam int W = pgr_pkg::SUM_W;

  logic signed [W:0] raw_x, raw_y;
  logic signed [W:0] ext_x, ext_y;
  logic signed [W:0] pos_d, neg_d, pos_t, neg_t;
  logic px, nx, py, ny;

  // saturating sum: 17-bit result, clamp when the top two bits disagree
  function automatic logic signed [W-1:0] sat(input logic signed [W:0] v);
    logic signed [W-1:0] r;
    if (v[W] != v[W-1]) begin
      r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    raw_x = {sum_x[W-1], sum_x} + {dx[W-1], dx};
    raw_y = {sum_y[W-1], sum_y} + {dy[W-1], dy};
    sum_x_next = sat(raw_x);
    sum_y_next = sat(raw_y);
    ext_x = {sum_x_next[W-1], sum_x_next};
    ext_y = {sum_y_next[W-1], sum_y_next};

    pos_d = {2'b00, diag_thr};
    neg_d = -pos_d;
    pos_t = {2'b00, move_thr};
    neg_t = -pos_t;

    px = ext_x > pos_d;
    nx = ext_x < neg_d;
    py = ext_y > pos_d;
    ny = ext_y < neg_d;

    cls.hit = 1'b1;
    if (nx && ny)            cls.dir = pgr_pkg::DIR_UP_LEFT;
    else if (px && ny)       cls.dir = pgr_pkg::DIR_UP_RIGHT;
    else if (nx && py)       cls.dir = pgr_pkg::DIR_DOWN_LEFT;
    else if (px && py)       cls.dir = pgr_pkg::DIR_DOWN_RIGHT;
    else if (ext_x < neg_t)  cls.dir = pgr_pkg::DIR_LEFT;
    else if (ext_x > pos_t)  cls.dir = pgr_pkg::DIR_RIGHT;
    else if (ext_y < neg_t)  cls.dir = pgr_pkg::DIR_UP;
    else if (ext_y > pos_t)  cls.dir = pgr_pkg::DIR_DOWN;
    else begin
      cls.hit = 1'b0;
      cls.dir = pgr_pkg::DIR_LEFT;
    end
  end

endmodule
